>>> src/sds_pkg.sv
// Shared types and constants for the SCAN disk scheduler.
// Holds the payload structs, the cell row entry and control types, and the register indexes.
package sds_pkg;

   localparam int TRACK_BITS     = 16;
   localparam int SEEK_BITS      = TRACK_BITS + 1;
   localparam int CYL_BITS       = TRACK_BITS + 1;
   localparam int KEY_BITS       = TRACK_BITS + 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = CYL_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CYLINDER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_HEAD     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWEEP_LEFT     = 2'd2;

   typedef struct packed {
      logic [TRACK_BITS-1:0] track;
      logic                  last_request;
   } req_type;

   typedef struct packed {
      logic [TRACK_BITS-1:0] visit_track;
      logic [SEEK_BITS-1:0]  seek_total;
      logic                  last_visit;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic                  forced;
      logic [TRACK_BITS-1:0] track;
   } entry_type;

   localparam entry_type ENTRY_EMPTY = '{valid: 1'b0, forced: 1'b0, track: '0};

   typedef logic [KEY_BITS-1:0] key_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_SORT,
      OP_DRAIN,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
      entry_type   load_ent;
   } cell_ctl_type;

   typedef struct packed {
      logic                  start;
      logic                  push;
      logic                  last;
      logic [TRACK_BITS-1:0] track;
   } emit_ctl_type;

endpackage

>>> src/scan_disk_scheduler_core.sv
// SCAN disk scheduler top level: configuration registers, batch sequencer and the cell row.
// Depends on sds_pkg, sds_cell and sds_emit.
//
// Requests are taken one per cycle until the beat flagged last_request; beyond MAX_REQUESTS
// held requests the track is dropped. After the last beat the block stalls its input for
// the whole batch: the disk end marker is added, odd-even compare-exchange rounds across
// the cell row sort the batch into service order, then one visit leaves per cycle while
// the output is not stalled, and finally the row is cleared. Configuration writes are always
// taken, but the values must hold from the first request of a batch until its final visit
// leaves, so write them only while no batch is in flight.
module scan_disk_scheduler_core import sds_pkg::*; #(
   parameter int MAX_REQUESTS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CELLS    = MAX_REQUESTS + 1;
   localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_MARK,
      ST_SORT,
      ST_DRAIN,
      ST_CLEAR
   } state_type;

   state_type             state_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   round_ff;
   logic [CYL_BITS-1:0]   cyl_count_ff;
   logic [TRACK_BITS-1:0] start_head_ff;
   logic                  sweep_left_ff;

   cell_ctl_type          cell_ctl;
   emit_ctl_type          emit_ctl;
   entry_type             ent_a [CELLS];
   key_type               key_a [CELLS];
   logic                  req_fire;
   logic                  kept0;
   logic                  kept1;
   logic                  can_push;
   logic [CYL_BITS-1:0]   end_wide;
   logic [TRACK_BITS-1:0] end_track;
   logic [TRACK_BITS-1:0] marker_track;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cyl_count_ff  <= {1'b1, {(CYL_BITS - 1){1'b0}}};
         start_head_ff <= '0;
         sweep_left_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CYLINDER_COUNT: cyl_count_ff  <= csr_wdata;
            CSR_START_HEAD:     start_head_ff <= csr_wdata[TRACK_BITS-1:0];
            CSR_SWEEP_LEFT:     sweep_left_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Disk end track: zero cylinders map to track zero, an oversized count clamps.
   always_comb begin
      end_wide = cyl_count_ff - CYL_BITS'(1);
      if (cyl_count_ff == '0) begin
         end_track = '0;
      end else if (end_wide[CYL_BITS-1]) begin
         end_track = '1;
      end else begin
         end_track = end_wide[TRACK_BITS-1:0];
      end
      marker_track = sweep_left_ff ? '0 : end_track;
   end

   assign req_stall = (state_ff != ST_COLLECT);
   assign req_fire  = req_valid && !req_stall;
   assign kept0     = !key_a[0][KEY_BITS-1];
   assign kept1     = !key_a[1][KEY_BITS-1];

   always_comb begin
      cell_ctl.op       = OP_HOLD;
      cell_ctl.phase    = round_ff[0];
      cell_ctl.load_ent = '{valid: 1'b1, forced: 1'b0, track: req_payload.track};
      emit_ctl.start    = 1'b0;
      emit_ctl.push     = 1'b0;
      emit_ctl.last     = !kept1;
      emit_ctl.track    = ent_a[0].track;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_fire && (count_ff < CNT_BITS'(MAX_REQUESTS))) begin
               cell_ctl.op = OP_LOAD;
            end
         end
         ST_MARK: begin
            cell_ctl.op       = OP_LOAD;
            cell_ctl.load_ent = '{valid: 1'b1, forced: 1'b1, track: marker_track};
            emit_ctl.start    = 1'b1;
         end
         ST_SORT: begin
            cell_ctl.op = OP_SORT;
         end
         ST_DRAIN: begin
            if (kept0 && can_push) begin
               cell_ctl.op   = OP_DRAIN;
               emit_ctl.push = 1'b1;
            end
         end
         ST_CLEAR: begin
            cell_ctl.op = OP_CLEAR;
         end
         default: begin
            cell_ctl.op = OP_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         round_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_COLLECT: begin
               if (req_fire) begin
                  if (count_ff < CNT_BITS'(MAX_REQUESTS)) begin
                     count_ff <= count_ff + CNT_BITS'(1);
                  end
                  if (req_payload.last_request) begin
                     state_ff <= ST_MARK;
                  end
               end
            end
            ST_MARK: begin
               round_ff <= '0;
               state_ff <= ST_SORT;
            end
            ST_SORT: begin
               round_ff <= round_ff + CNT_BITS'(1);
               if (round_ff == CNT_BITS'(MAX_REQUESTS)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (emit_ctl.push && emit_ctl.last) begin
                  state_ff <= ST_CLEAR;
               end
            end
            ST_CLEAR: begin
               count_ff <= '0;
               state_ff <= ST_COLLECT;
            end
            default: begin
               state_ff <= ST_COLLECT;
            end
         endcase
      end
   end

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      entry_type left_ent;
      entry_type right_ent;
      key_type   left_key;
      key_type   right_key;

      if (i == 0) begin : g_first
         assign left_ent = cell_ctl.load_ent;
         assign left_key = '0;
      end else begin : g_inner_left
         assign left_ent = ent_a[i-1];
         assign left_key = key_a[i-1];
      end

      if (i == CELLS - 1) begin : g_last
         assign right_ent = ENTRY_EMPTY;
         assign right_key = '1;
      end else begin : g_inner_right
         assign right_ent = ent_a[i+1];
         assign right_key = key_a[i+1];
      end

      sds_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .head       (start_head_ff),
         .sweep_left (sweep_left_ff),
         .left_ent   (left_ent),
         .left_key   (left_key),
         .right_ent  (right_ent),
         .right_key  (right_key),
         .ent        (ent_a[i]),
         .key        (key_a[i])
      );
   end

   sds_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .ctl         (emit_ctl),
      .start_head  (start_head_ff),
      .can_push    (can_push),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The marker is always kept, so the row front holds a visit until the last one leaves.
   a_drain_front_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> kept0)
      else $error("cell row front empty while draining");

   // After the sort rounds the row front is in service order.
   a_drain_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (key_a[0] <= key_a[1]))
      else $error("cell row not sorted while draining");

   // Loading never pushes an entry off the top of the row.
   a_top_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COLLECT) |-> !ent_a[CELLS-1].valid)
      else $error("top cell occupied while collecting");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_REQUESTS))
      else $error("request count above capacity");

endmodule

>>> src/sds_cell.sv
// One cell of the request row: holds one track entry and its service-order key.
// Depends on sds_pkg for the entry, key and control types.
module sds_cell import sds_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [TRACK_BITS-1:0] head,
   input  logic                  sweep_left,
   input  entry_type             left_ent,
   input  key_type               left_key,
   input  entry_type             right_ent,
   input  key_type               right_key,
   output entry_type             ent,
   output key_type               key
);

   localparam logic ODD = (INDEX % 2) == 1;

   entry_type ent_ff;
   entry_type ent_in;
   logic      lo_side;
   logic      kept;
   logic      group;
   logic [TRACK_BITS-1:0] trk_val;

   // The key orders entries by service: first-sweep side, then the return side.
   // Tracks served while moving toward zero use the inverted value so they sort descending.
   always_comb begin
      lo_side = ent_ff.forced ? sweep_left : (ent_ff.track < head);
      kept    = ent_ff.valid && (ent_ff.forced || (ent_ff.track != head));
      group   = sweep_left ? !lo_side : lo_side;
      trk_val = lo_side ? ~ent_ff.track : ent_ff.track;
      key     = kept ? {1'b0, group, trk_val} : '1;
   end

   always_comb begin
      ent_in = ent_ff;
      unique case (ctl.op)
         OP_HOLD: begin
            ent_in = ent_ff;
         end
         OP_LOAD: begin
            ent_in = left_ent;
         end
         OP_SORT: begin
            if (ODD == ctl.phase) begin
               if (key > right_key) begin
                  ent_in = right_ent;
               end
            end else begin
               if (left_key > key) begin
                  ent_in = left_ent;
               end
            end
         end
         OP_DRAIN: begin
            ent_in = right_ent;
         end
         OP_CLEAR: begin
            ent_in.valid = 1'b0;
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   // Only the valid bit needs a reset value; the payload fields follow it.
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
      ent_ff.forced <= ent_in.forced;
      ent_ff.track  <= ent_in.track;
   end

   assign ent = ent_ff;

endmodule

>>> src/sds_emit.sv
// Result stage: tracks the head position, sums the seek distance and holds the output beat.
// Depends on sds_pkg for the result payload and the emit control struct.
module sds_emit import sds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  emit_ctl_type          ctl,
   input  logic [TRACK_BITS-1:0] start_head,
   output logic                  can_push,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload
);

   logic [TRACK_BITS-1:0] head_ff;
   logic [TRACK_BITS-1:0] head_in;
   logic [SEEK_BITS-1:0]  sum_ff;
   logic [SEEK_BITS-1:0]  sum_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [TRACK_BITS-1:0] seek_step;
   logic [SEEK_BITS:0]    sum_wide;
   logic [SEEK_BITS-1:0]  sum_sat;

   assign can_push = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      seek_step = (ctl.track >= head_ff) ? (ctl.track - head_ff) : (head_ff - ctl.track);
      sum_wide  = {1'b0, sum_ff} + {{(SEEK_BITS + 1 - TRACK_BITS){1'b0}}, seek_step};
      // The running total saturates at its all-ones value.
      sum_sat   = sum_wide[SEEK_BITS] ? '1 : sum_wide[SEEK_BITS-1:0];
   end

   always_comb begin
      head_in      = head_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.start) begin
         head_in = start_head;
         sum_in  = '0;
      end else if (ctl.push) begin
         head_in      = ctl.track;
         sum_in       = sum_sat;
         rsp_in       = '{visit_track: ctl.track, seek_total: sum_sat, last_visit: ctl.last};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         sum_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
